// ===== hdl/pstd_pkg.sv =====
package pstd_pkg;

    // Sample and result formats.
    localparam int SAMPLE_BITS      = 24;
    localparam int DB_FRACTION_BITS = 7;
    localparam int LEVEL_BITS       = 16;

    // Power word, exponent and normalization widths.
    localparam int PW_BITS   = 2 * SAMPLE_BITS;
    localparam int EXP_BITS  = $clog2(PW_BITS);
    localparam int Q_FRAC    = 30;
    localparam int MANT_BITS = Q_FRAC + 1;
    localparam int NORM_BITS = (PW_BITS > MANT_BITS) ? PW_BITS : MANT_BITS;
    localparam int SHIFT_BITS = $clog2(NORM_BITS);

    // dB result width before the offset is added.
    localparam int TERM_BITS = 40;
    localparam int DB_BITS   = TERM_BITS - (Q_FRAC - DB_FRACTION_BITS);

    // Fixed-point constants in Q30.
    localparam logic [MANT_BITS-1:0] QONE      = MANT_BITS'(64'd1073741824);
    localparam logic [MANT_BITS-1:0] C_SEVENTH = MANT_BITS'(64'd153391689);
    localparam logic [MANT_BITS-1:0] C_FIFTH   = MANT_BITS'(64'd214748365);
    localparam logic [MANT_BITS-1:0] C_THIRD   = MANT_BITS'(64'd357913941);
    localparam logic [33:0]          K_LOGM    = 34'd9326402983;
    localparam logic [31:0]          K_LOG2    = 32'd3232284966;

    // Configuration register indexes.
    localparam int CFG_INDEX_BITS = 1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_DB_OFFSET = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_DB_FLOOR  = 1'b1;
    localparam logic signed [LEVEL_BITS-1:0] DB_FLOOR_RESET = -16'sd30720;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] bin_real;
        logic signed [SAMPLE_BITS-1:0] bin_imag;
        logic                          last_bin;
    } bin_t;

    typedef struct packed {
        logic signed [LEVEL_BITS-1:0] level_db;
        logic                         frame_end;
    } level_t;

    typedef struct packed {
        logic signed [LEVEL_BITS-1:0] db_offset;
        logic signed [LEVEL_BITS-1:0] db_floor;
    } cfg_t;

    // Word passed from the front end to the back end.
    typedef struct packed {
        logic [MANT_BITS-1:0] mant;
        logic [EXP_BITS-1:0]  expo;
        logic                 zero;
        logic                 last;
    } norm_t;

endpackage

// ===== hdl/pstd_front.sv =====
module pstd_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  pstd_pkg::bin_t   in_word,
    output logic             push,
    output pstd_pkg::norm_t  push_word,
    input  logic             full
);

    localparam int S  = pstd_pkg::SAMPLE_BITS;
    localparam int PW = pstd_pkg::PW_BITS;
    localparam int EW = pstd_pkg::EXP_BITS;
    localparam int NW = pstd_pkg::NORM_BITS;
    localparam int SW = pstd_pkg::SHIFT_BITS;
    localparam int MW = pstd_pkg::MANT_BITS;

    logic          en;
    logic          v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic [S-1:0]  mre_reg, mim_reg;
    logic          l1_reg, l2_reg, l3_reg, l4_reg;
    logic [PW-1:0] sqr_reg, sqi_reg;
    logic [PW-1:0] pw3_reg, pw4_reg;
    logic          z3_reg, z4_reg;
    logic [EW-1:0] e4_reg;
    logic [EW-1:0] e_next;
    logic [S-1:0]  mre_next, mim_next;
    logic [SW-1:0] sh;
    logic [NW-1:0] norm;
    pstd_pkg::norm_t w5_reg, w5_next;

    // The whole front pipeline holds when its last word cannot enter the queue.
    assign en       = !(v5_reg && full);
    assign in_stall = !en;
    assign push     = v5_reg && !full;
    assign push_word = w5_reg;

    assign mre_next = in_word.bin_real[S-1] ? (~in_word.bin_real + S'(1)) : in_word.bin_real;
    assign mim_next = in_word.bin_imag[S-1] ? (~in_word.bin_imag + S'(1)) : in_word.bin_imag;

    always_comb
    begin
        e_next = '0;
        for (int i = 0; i < PW; i++)
        begin
            if (pw3_reg[i])
            begin
                e_next = EW'(i);
            end
        end
    end

    always_comb
    begin
        sh   = SW'(NW - 1) - SW'(e4_reg);
        norm = NW'(pw4_reg) << sh;
        w5_next.mant = z4_reg ? pstd_pkg::QONE : norm[NW-1 -: MW];
        w5_next.expo = e4_reg;
        w5_next.zero = z4_reg;
        w5_next.last = l4_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mre_reg <= mre_next;
            mim_reg <= mim_next;
            l1_reg  <= in_word.last_bin;
            sqr_reg <= PW'(mre_reg) * PW'(mre_reg);
            sqi_reg <= PW'(mim_reg) * PW'(mim_reg);
            l2_reg  <= l1_reg;
            pw3_reg <= sqr_reg + sqi_reg;
            z3_reg  <= (sqr_reg == '0) && (sqi_reg == '0);
            l3_reg  <= l2_reg;
            pw4_reg <= pw3_reg;
            e4_reg  <= e_next;
            z4_reg  <= z3_reg;
            l4_reg  <= l3_reg;
            w5_reg  <= w5_next;
        end
    end

endmodule

// ===== hdl/pstd_queue.sv =====
module pstd_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  pstd_pkg::norm_t  push_word,
    output logic             full,
    input  logic             pop,
    output logic             not_empty,
    output pstd_pkg::norm_t  pop_word
);

    localparam int DEPTH = 4;
    localparam int AW    = $clog2(DEPTH);

    pstd_pkg::norm_t mem [DEPTH];
    logic [AW-1:0]   wp_reg, rp_reg;
    logic [AW:0]     cnt_reg;

    assign full      = (cnt_reg == (AW+1)'(DEPTH));
    assign not_empty = (cnt_reg != '0);
    assign pop_word  = mem[rp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= wp_reg + AW'(1);
            end
            if (pop)
            begin
                rp_reg <= rp_reg + AW'(1);
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + (AW+1)'(1);
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - (AW+1)'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wp_reg] <= push_word;
        end
    end

endmodule

// ===== hdl/pstd_back.sv =====
module pstd_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_valid,
    input  pstd_pkg::norm_t  q_word,
    output logic             pop,
    input  pstd_pkg::cfg_t   cfg,
    output logic             out_valid,
    input  logic             out_stall,
    output pstd_pkg::level_t out_word
);

    localparam int QF  = pstd_pkg::Q_FRAC;
    localparam int MW  = pstd_pkg::MANT_BITS;
    localparam int EW  = pstd_pkg::EXP_BITS;
    localparam int F   = pstd_pkg::DB_FRACTION_BITS;
    localparam int TW  = pstd_pkg::TERM_BITS;
    localparam int DBW = pstd_pkg::DB_BITS;
    localparam int LB  = pstd_pkg::LEVEL_BITS;
    localparam int LW  = DBW + 2;
    localparam int KH  = 17;
    localparam int RW  = MW + 1;

    localparam logic signed [LW-1:0] SAT_HI = LW'(32767);
    localparam logic signed [LW-1:0] SAT_LO = -(LW'(32768));

    logic en;

    // Divider: one quotient bit per stage.
    logic          dv_reg [QF+1];
    logic [RW-1:0] dr_reg [QF+1];
    logic [RW-1:0] dd_reg [QF+1];
    logic [QF-1:0] dq_reg [QF+1];
    logic [EW-1:0] de_reg [QF+1];
    logic          dz_reg [QF+1];
    logic          dl_reg [QF+1];

    // Polynomial and scaling stages.
    logic          v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, v7_reg;
    logic [QF-1:0] y1_reg, y2_reg, y3_reg, y4_reg;
    logic [QF-1:0] ysq1_reg, ysq2_reg, ysq3_reg;
    logic [MW-1:0] p2_reg, p3_reg, p4_reg, yp5_reg;
    logic [MW+KH-1:0] a6_reg, b6_reg;
    logic [DBW-1:0] db7_reg;
    logic [EW-1:0] e1_reg, e2_reg, e3_reg, e4_reg, e5_reg, e6_reg;
    logic          z1_reg, z2_reg, z3_reg, z4_reg, z5_reg, z6_reg, z7_reg;
    logic          l1_reg, l2_reg, l3_reg, l4_reg, l5_reg, l6_reg, l7_reg;
    logic          ov_reg;
    pstd_pkg::level_t ow_reg, ow_next;

    logic [2*QF-1:0]      ysq_prod;
    logic [MW+QF-1:0]     p2_prod, p3_prod, p4_prod, yp_prod;
    logic [MW+KH+KH-1:0]  full_prod;
    logic [TW-1:0]        term, term_rnd;
    logic signed [LW-1:0] lvl;
    logic signed [LB-1:0] sat;

    assign en        = !ov_reg || !out_stall;
    assign pop       = en && q_valid;
    assign out_valid = ov_reg;
    assign out_word  = ow_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            dv_reg[0] <= q_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dr_reg[0] <= RW'(q_word.mant - pstd_pkg::QONE);
            dd_reg[0] <= RW'(q_word.mant) + RW'(pstd_pkg::QONE);
            dq_reg[0] <= '0;
            de_reg[0] <= q_word.expo;
            dz_reg[0] <= q_word.zero;
            dl_reg[0] <= q_word.last;
        end
    end

    for (genvar k = 1; k <= QF; k++)
    begin : g_div
        logic [RW:0]   r2;
        logic          ge;
        logic [RW-1:0] r_next;

        always_comb
        begin
            r2     = {dr_reg[k-1], 1'b0};
            ge     = (r2 >= {1'b0, dd_reg[k-1]});
            r_next = ge ? RW'(r2 - {1'b0, dd_reg[k-1]}) : RW'(r2);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                dv_reg[k] <= dv_reg[k-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dr_reg[k] <= r_next;
                dd_reg[k] <= dd_reg[k-1];
                dq_reg[k] <= {dq_reg[k-1][QF-2:0], ge};
                de_reg[k] <= de_reg[k-1];
                dz_reg[k] <= dz_reg[k-1];
                dl_reg[k] <= dl_reg[k-1];
            end
        end
    end

    always_comb
    begin
        ysq_prod  = (2*QF)'(dq_reg[QF]) * (2*QF)'(dq_reg[QF]);
        p2_prod   = (MW+QF)'(pstd_pkg::C_SEVENTH) * (MW+QF)'(ysq1_reg);
        p3_prod   = (MW+QF)'(p2_reg) * (MW+QF)'(ysq2_reg);
        p4_prod   = (MW+QF)'(p3_reg) * (MW+QF)'(ysq3_reg);
        yp_prod   = (MW+QF)'(y4_reg) * (MW+QF)'(p4_reg);
        full_prod = {a6_reg, KH'(0)} + (MW+KH+KH)'(b6_reg);
        term      = TW'(full_prod >> QF) + TW'(e6_reg) * TW'(pstd_pkg::K_LOG2);
        term_rnd  = term + (TW'(1) << (QF - 1 - F));
    end

    // Offset, saturation and floor clamp.
    always_comb
    begin
        lvl = $signed({2'b00, db7_reg}) + LW'(cfg.db_offset);
        if (lvl > SAT_HI)
        begin
            sat = LB'(SAT_HI);
        end
        else if (lvl < SAT_LO)
        begin
            sat = LB'(SAT_LO);
        end
        else
        begin
            sat = LB'(lvl);
        end
        if (z7_reg || (sat < cfg.db_floor))
        begin
            ow_next.level_db = cfg.db_floor;
        end
        else
        begin
            ow_next.level_db = sat;
        end
        ow_next.frame_end = l7_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
            ov_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= dv_reg[QF];
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
            v7_reg <= v6_reg;
            ov_reg <= v7_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            y1_reg   <= dq_reg[QF];
            ysq1_reg <= ysq_prod[2*QF-1:QF];
            e1_reg   <= de_reg[QF];
            z1_reg   <= dz_reg[QF];
            l1_reg   <= dl_reg[QF];

            y2_reg   <= y1_reg;
            ysq2_reg <= ysq1_reg;
            p2_reg   <= p2_prod[MW+QF-1:QF] + pstd_pkg::C_FIFTH;
            e2_reg   <= e1_reg;
            z2_reg   <= z1_reg;
            l2_reg   <= l1_reg;

            y3_reg   <= y2_reg;
            ysq3_reg <= ysq2_reg;
            p3_reg   <= p3_prod[MW+QF-1:QF] + pstd_pkg::C_THIRD;
            e3_reg   <= e2_reg;
            z3_reg   <= z2_reg;
            l3_reg   <= l2_reg;

            y4_reg   <= y3_reg;
            p4_reg   <= p4_prod[MW+QF-1:QF] + pstd_pkg::QONE;
            e4_reg   <= e3_reg;
            z4_reg   <= z3_reg;
            l4_reg   <= l3_reg;

            yp5_reg  <= yp_prod[MW+QF-1:QF];
            e5_reg   <= e4_reg;
            z5_reg   <= z4_reg;
            l5_reg   <= l4_reg;

            a6_reg   <= (MW+KH)'(yp5_reg) * (MW+KH)'(pstd_pkg::K_LOGM[33:KH]);
            b6_reg   <= (MW+KH)'(yp5_reg) * (MW+KH)'(pstd_pkg::K_LOGM[KH-1:0]);
            e6_reg   <= e5_reg;
            z6_reg   <= z5_reg;
            l6_reg   <= l5_reg;

            db7_reg  <= term_rnd[TW-1:QF-F];
            z7_reg   <= z6_reg;
            l7_reg   <= l6_reg;

            ow_reg   <= ow_next;
        end
    end

endmodule

// ===== hdl/power_spectrum_to_db.sv =====
// Power spectrum to decibel converter.
//
// Each word on the bin channel carries one complex spectrum bin (signed
// real and imaginary parts) and a frame marker. For every bin the block
// returns one word on the level channel: 10*log10(I*I + Q*Q) in 1/128 dB,
// plus the configured offset, saturated to 16 bits and clamped from below
// to the configured floor. A bin of zero power gives the floor itself.
// The frame marker travels alongside unchanged.
//
// Throughput is one bin per clock while the receiver does not stall.
// An accepted bin passes through five front-end stages (magnitude,
// squares, sum, leading-one search, normalize), the four-entry queue,
// thirty-one divider stages, all but the first forming one quotient bit
// of (m-1)/(m+1), and eight polynomial, scaling and clamp stages ending
// in the output register.
//
// When the receiver stalls, the back end freezes and the queue fills; the
// front end keeps taking bins until the queue is full. Reset clears all
// valid state and sets the offset to 0 dB and the floor to -240 dB.
// The offset and floor registers should be written while no bin is in
// flight.
module power_spectrum_to_db (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  bin_valid,
    output logic                                  bin_stall,
    input  pstd_pkg::bin_t                        bin_word,
    output logic                                  level_valid,
    input  logic                                  level_stall,
    output pstd_pkg::level_t                      level_word,
    input  logic                                  cfg_write,
    input  logic [pstd_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [pstd_pkg::LEVEL_BITS-1:0]       cfg_data
);

    pstd_pkg::cfg_t  cfg_reg;
    pstd_pkg::norm_t push_word, pop_word;
    logic            push, pop, full, not_empty;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.db_offset <= '0;
            cfg_reg.db_floor  <= pstd_pkg::DB_FLOOR_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                pstd_pkg::REG_DB_OFFSET: cfg_reg.db_offset <= $signed(cfg_data);
                pstd_pkg::REG_DB_FLOOR:  cfg_reg.db_floor  <= $signed(cfg_data);
                default:                 ;
            endcase
        end
    end

    // Front end: magnitude, power and normalization into mantissa and exponent.
    pstd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (bin_valid),
        .in_stall  (bin_stall),
        .in_word   (bin_word),
        .push      (push),
        .push_word (push_word),
        .full      (full)
    );

    // Short queue that decouples the two halves.
    pstd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_word (push_word),
        .full      (full),
        .pop       (pop),
        .not_empty (not_empty),
        .pop_word  (pop_word)
    );

    // Back end: divider, log polynomial, scaling and clamping.
    pstd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (not_empty),
        .q_word    (pop_word),
        .pop       (pop),
        .cfg       (cfg_reg),
        .out_valid (level_valid),
        .out_stall (level_stall),
        .out_word  (level_word)
    );

endmodule

// ===== hdl/pstd_checker.sv =====
module pstd_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             bin_valid,
    input logic             bin_stall,
    input logic             level_valid,
    input logic             level_stall,
    input pstd_pkg::level_t level_word
);

    logic [7:0] inflight_reg;
    logic       in_acc, out_acc;

    assign in_acc  = bin_valid && !bin_stall;
    assign out_acc = level_valid && !level_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inflight_reg <= '0;
        end
        else if (in_acc && !out_acc)
        begin
            inflight_reg <= inflight_reg + 8'd1;
        end
        else if (out_acc && !in_acc)
        begin
            inflight_reg <= inflight_reg - 8'd1;
        end
    end

    // A stalled level word stays put.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        level_valid && level_stall |=> level_valid && $stable(level_word))
        else $error("level word changed while stalled");

    // No level word without a bin in flight.
    a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
        level_valid |-> inflight_reg != 8'd0)
        else $error("level word without an accepted bin");

    // No more than 50 bins are ever in flight in the stages and queue.
    a_bound: assert property (@(posedge clk) disable iff (!rst_n)
        inflight_reg <= 8'd50)
        else $error("too many bins in flight");

    // Nothing is shown during reset.
    a_reset: assert property (@(posedge clk)
        !rst_n |-> !level_valid)
        else $error("level valid during reset");

endmodule

bind power_spectrum_to_db pstd_checker u_pstd_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .bin_valid   (bin_valid),
    .bin_stall   (bin_stall),
    .level_valid (level_valid),
    .level_stall (level_stall),
    .level_word  (level_word)
);
